@@ hw/rtl/etfl_pkg.sv @@
package etfl_pkg;

  localparam int LANE_COUNT      = 4;
  localparam int IMG_WIDTH_DEF   = 1024;
  localparam int IMG_HEIGHT_DEF  = 1024;
  localparam int MAX_ITER_DEF    = 256;

  localparam int COORD_W  = 32;   // Q6.26
  localparam int FRAC_W   = 26;
  localparam int PROD_W   = 64;   // Q12.52
  localparam int SUM_W    = 40;   // z update before saturation
  localparam int POS_W    = 13;   // column_base + lane may pass 4095
  localparam int ORG_W    = 13;
  localparam int LIMIT_W  = 11;
  localparam int COLOR_W  = 24;
  localparam int IN_W     = 12;
  localparam int DELTA_W  = 15;
  localparam int MAG_W    = 14;
  localparam int SCALE_SH = FRAC_W + 2;        // times 4 in Q6.26
  localparam int NUM_W    = MAG_W + SCALE_SH;  // mapper dividend width
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    REG_X_ORIGIN  = 2'd0,
    REG_Y_ORIGIN  = 2'd1,
    REG_ESC_LIMIT = 2'd2
  } reg_idx_t;

  localparam logic signed [ORG_W-1:0] X_ORIGIN_RST = 13'sd640;
  localparam logic signed [ORG_W-1:0] Y_ORIGIN_RST = 13'sd512;
  localparam logic [LIMIT_W-1:0]      ESC_LIMIT_RST = 11'd100;

  typedef struct packed {
    logic               done;
    logic               escaped;
    logic [COLOR_W-1:0] color;
  } lane_res_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic hi_same;
    hi_same = (&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1]);
    if (hi_same) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ hw/rtl/etfl_map.sv @@
module etfl_map #(
  parameter int DIM = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [etfl_pkg::POS_W-1:0]           pos,
  input  logic signed [etfl_pkg::ORG_W-1:0]    origin,
  output logic signed [etfl_pkg::COORD_W-1:0]  coord,
  output logic                                 done
);
  import etfl_pkg::*;

  // |pos - origin| * 2^28 / DIM split as mag * (2^28 div DIM) plus
  // (mag * (2^28 mod DIM)) / DIM; the second dividend stays below 2^Y_W,
  // so a reciprocal multiply with RSH = Y_W + log2(DIM) is exact
  localparam int QC_W = 25;              // 2^28 / DIM with DIM >= 16
  localparam int RC_W = 12;              // 2^28 mod DIM with DIM <= 4096
  localparam int RM_W = 28;
  localparam int Y_W  = MAG_W + RC_W;
  localparam int HI_W = MAG_W + QC_W;
  localparam int LO_W = Y_W + RM_W;
  localparam int RSH  = Y_W + $clog2(DIM);

  localparam logic [QC_W-1:0] Q_C  = QC_W'((64'd1 << SCALE_SH) / 64'(DIM));
  localparam logic [RC_W-1:0] R_C  = RC_W'((64'd1 << SCALE_SH) % 64'(DIM));
  localparam logic [RM_W-1:0] RM_C = RM_W'(((64'd1 << RSH) + 64'(DIM) - 64'd1) / 64'(DIM));

  // start -> magnitude, -> partial products, -> quotient; done is registered with the quotient
  logic [MAG_W-1:0]        mag_r;
  logic                    neg_r;
  logic [HI_W-1:0]         hi_r;
  logic [Y_W-1:0]          y_r;
  logic [NUM_W-1:0]        quo_r;
  logic                    s1_r;
  logic                    s2_r;
  logic                    done_r;

  logic signed [DELTA_W-1:0] delta;
  logic [MAG_W-1:0]          mag;
  logic [HI_W-1:0]           hi_prod;
  logic [Y_W-1:0]            y_prod;
  logic [LO_W-1:0]           lo_prod;
  logic                      over;

  always_comb begin
    delta   = $signed({2'b00, pos}) - $signed({{(DELTA_W-ORG_W){origin[ORG_W-1]}}, origin});
    mag     = delta[DELTA_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
    hi_prod = mag_r * Q_C;
    y_prod  = mag_r * R_C;
    lo_prod = y_r * RM_C;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r <= start;
      s2_r <= s1_r;
      if (start) begin
        done_r <= 1'b0;
      end else if (s2_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag;
      neg_r <= delta[DELTA_W-1];
    end
    if (s1_r) begin
      hi_r <= hi_prod;
      y_r  <= y_prod;
    end
    if (s2_r) begin
      quo_r <= NUM_W'(hi_r) + NUM_W'(lo_prod >> RSH);
    end
  end

  // sign and saturate the quotient to Q6.26
  always_comb begin
    if (neg_r) begin
      over  = (|quo_r[NUM_W-1:COORD_W]) || (quo_r[COORD_W-1] && |quo_r[COORD_W-2:0]);
      coord = over ? {1'b1, {(COORD_W-1){1'b0}}} : -$signed(quo_r[COORD_W-1:0]);
    end else begin
      over  = (|quo_r[NUM_W-1:COORD_W]) || quo_r[COORD_W-1];
      coord = over ? {1'b0, {(COORD_W-1){1'b1}}} : $signed(quo_r[COORD_W-1:0]);
    end
  end

  assign done = done_r;

endmodule

@@ hw/rtl/etfl_lane.sv @@
module etfl_lane #(
  parameter int MAX_ITER = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                take,
  input  logic signed [etfl_pkg::COORD_W-1:0] cr,
  input  logic signed [etfl_pkg::COORD_W-1:0] ci,
  input  logic [etfl_pkg::LIMIT_W-1:0]        limit,
  output etfl_pkg::lane_res_t                 res
);
  import etfl_pkg::*;

  localparam int IT_W  = $clog2(MAX_ITER + 1);
  localparam int CLR_W = $clog2(MAX_ITER);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_ADD  = 4'b0100,
    L_DONE = 4'b1000
  } lane_state_t;

  lane_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] zr_r, zi_r, cr_r, ci_r;
  logic signed [PROD_W-1:0]  prr_r, pii_r, pri_r;
  logic [IT_W-1:0]           it_r;
  logic [CLR_W-1:0]          racc_r;   // (index of last iteration * 5) mod MAX_ITER
  logic [COLOR_W-1:0]        color_r;
  logic                      esc_r;

  logic signed [PROD_W-1:0]  pri_adj;
  logic signed [SUM_W-1:0]   rr_e, ii_e, ri2_e, cr_e, ci_e;
  logic signed [COORD_W-1:0] nr, ni;
  logic [PROD_W-1:0]         mag, lim;
  logic                      hit;
  logic [CLR_W:0]            racc_inc;
  logic [CLR_W-1:0]          racc_nxt;
  logic [CLR_W-1:0]          g_val, b_val;

  function automatic logic [CLR_W-1:0] mod_dbl(input logic [CLR_W-1:0] v);
    logic [CLR_W:0] t;
    t = {v, 1'b0};
    if (t >= (CLR_W+1)'(MAX_ITER)) begin
      t = t - (CLR_W+1)'(MAX_ITER);
    end
    return t[CLR_W-1:0];
  endfunction

  function automatic logic [7:0] low_byte(input logic [CLR_W-1:0] v);
    logic [CLR_W+7:0] w;
    w = (CLR_W+8)'(v);
    return w[7:0];
  endfunction

  always_comb begin
    // truncate toward zero when dropping the 26 fraction bits
    pri_adj = pri_r + (pri_r[PROD_W-1] ? $signed(PROD_W'((64'd1 << FRAC_W) - 64'd1))
                                        : $signed(PROD_W'(0)));
    rr_e  = $signed({2'b00, prr_r[PROD_W-1:FRAC_W]});
    ii_e  = $signed({2'b00, pii_r[PROD_W-1:FRAC_W]});
    ri2_e = $signed({pri_adj[PROD_W-1], pri_adj[PROD_W-1:FRAC_W], 1'b0});
    cr_e  = $signed({{(SUM_W-COORD_W){cr_r[COORD_W-1]}}, cr_r});
    ci_e  = $signed({{(SUM_W-COORD_W){ci_r[COORD_W-1]}}, ci_r});
    nr    = sat32(rr_e - ii_e + cr_e);
    ni    = sat32(ri2_e + ci_e);
    // squares of the current z sum to its squared magnitude for the escape test
    mag   = $unsigned(prr_r) + $unsigned(pii_r);
    lim   = {1'b0, limit, {(PROD_W-LIMIT_W-1){1'b0}}};
    hit   = (mag > lim);
    racc_inc = (CLR_W+1)'(racc_r) + (CLR_W+1)'(5);
    if (it_r == '0) begin
      racc_nxt = '0;
    end else if (racc_inc >= (CLR_W+1)'(MAX_ITER)) begin
      racc_nxt = CLR_W'(racc_inc - (CLR_W+1)'(MAX_ITER));
    end else begin
      racc_nxt = racc_inc[CLR_W-1:0];
    end
    g_val = mod_dbl(racc_r);
    b_val = mod_dbl(g_val);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: if (start) state_nxt = L_MUL;
      L_MUL:  state_nxt = L_ADD;
      L_ADD: begin
        if (hit || it_r == IT_W'(MAX_ITER)) begin
          state_nxt = L_DONE;
        end else begin
          state_nxt = L_MUL;
        end
      end
      L_DONE: if (take) state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == L_IDLE && start) begin
      zr_r <= '0;
      zi_r <= '0;
      cr_r <= cr;
      ci_r <= ci;
      it_r <= '0;
    end else if (state_r == L_MUL) begin
      prr_r <= zr_r * zr_r;
      pii_r <= zi_r * zi_r;
      pri_r <= zr_r * zi_r;
    end else if (state_r == L_ADD) begin
      if (hit) begin
        color_r <= {low_byte(racc_r), low_byte(g_val), low_byte(b_val)};
        esc_r   <= 1'b1;
      end else if (it_r == IT_W'(MAX_ITER)) begin
        color_r <= '0;
        esc_r   <= 1'b0;
      end else begin
        zr_r   <= nr;
        zi_r   <= ni;
        it_r   <= it_r + 1'b1;
        racc_r <= racc_nxt;
      end
    end
  end

  always_comb begin
    res.done    = (state_r == L_DONE);
    res.escaped = esc_r;
    res.color   = color_r;
  end

endmodule

@@ hw/rtl/etfl_merge.sv @@
module etfl_merge (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  etfl_pkg::lane_res_t [etfl_pkg::LANE_COUNT-1:0]         lane_res,
  input  logic                                                   out_stall,
  output logic                                                   load,
  output logic                                                   out_valid,
  output logic [etfl_pkg::LANE_COUNT-1:0][etfl_pkg::COLOR_W-1:0] color,
  output logic [etfl_pkg::LANE_COUNT-1:0]                        escaped
);
  import etfl_pkg::*;

  logic                                  valid_r;
  logic [LANE_COUNT-1:0][COLOR_W-1:0]    color_r;
  logic [LANE_COUNT-1:0]                 esc_r;
  logic [LANE_COUNT-1:0]                 done_vec;

  always_comb begin
    for (int j = 0; j < LANE_COUNT; j++) begin
      done_vec[j] = lane_res[j].done;
    end
    // all lanes finished and the output register is free or emptying now
    load = (&done_vec) && (!valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < LANE_COUNT; j++) begin
        color_r[j] <= lane_res[j].color;
        esc_r[j]   <= lane_res[j].escaped;
      end
    end
  end

  assign out_valid = valid_r;
  assign color     = color_r;
  assign escaped   = esc_r;

endmodule

@@ hw/rtl/escape_time_fractal_lanes_top.sv @@
// Escape-time fractal evaluator, four pixels per request. A request carries
// the column of the leftmost pixel and the row; each of four lanes maps its
// pixel to a Q6.26 point with a reciprocal multiply (all lanes at once),
// then iterates z = z*z + c in its own multiplier set, each iteration
// registering the products, then updating z and checking for escape. A
// request shows on out_valid once the slowest lane has finished, plus any
// wait for a stalled output register. One request is in flight at a time;
// the finished colors sit in an output register, so the next request is
// taken while a result still waits on out_stall. Registers: x_origin at
// 0x0, y_origin at 0x4, escape_limit at 0x8; write them only while idle.
module escape_time_fractal_lanes_top #(
  parameter int IMG_WIDTH  = etfl_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = etfl_pkg::IMG_HEIGHT_DEF,
  parameter int MAX_ITER   = etfl_pkg::MAX_ITER_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [etfl_pkg::IN_W-1:0]     in_column_base,
  input  logic [etfl_pkg::IN_W-1:0]     in_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [etfl_pkg::COLOR_W-1:0]  out_color_lane0,
  output logic [etfl_pkg::COLOR_W-1:0]  out_color_lane1,
  output logic [etfl_pkg::COLOR_W-1:0]  out_color_lane2,
  output logic [etfl_pkg::COLOR_W-1:0]  out_color_lane3,
  output logic                          out_escaped_lane0,
  output logic                          out_escaped_lane1,
  output logic                          out_escaped_lane2,
  output logic                          out_escaped_lane3,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [etfl_pkg::ADDR_W-1:0]   paddr,
  input  logic [etfl_pkg::DATA_W-1:0]   pwdata,
  output logic [etfl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import etfl_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_MAP  = 3'b010,
    T_RUN  = 3'b100
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic signed [ORG_W-1:0] x_origin_r, y_origin_r;
  logic [LIMIT_W-1:0]      limit_r;

  logic                    accept;
  logic                    cfg_wr;
  reg_idx_t                reg_idx;
  logic [LANE_COUNT:0]     map_done;
  logic                    all_map_done;
  logic                    lane_start;
  logic                    load;

  logic signed [COORD_W-1:0]             cr [LANE_COUNT];
  logic signed [COORD_W-1:0]             ci;
  lane_res_t [LANE_COUNT-1:0]            lane_res;
  logic [LANE_COUNT-1:0][COLOR_W-1:0]    m_color;
  logic [LANE_COUNT-1:0]                 m_esc;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= X_ORIGIN_RST;
      y_origin_r <= Y_ORIGIN_RST;
      limit_r    <= ESC_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_X_ORIGIN:  x_origin_r <= $signed(pwdata[ORG_W-1:0]);
        REG_Y_ORIGIN:  y_origin_r <= $signed(pwdata[ORG_W-1:0]);
        REG_ESC_LIMIT: limit_r    <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_ORIGIN:  prdata = DATA_W'(x_origin_r);
      REG_Y_ORIGIN:  prdata = DATA_W'(y_origin_r);
      REG_ESC_LIMIT: prdata = DATA_W'(limit_r);
      default:       prdata = '0;
    endcase
  end

  // request sequencing
  assign in_stall     = (state_r != T_IDLE);
  assign accept       = in_valid && !in_stall;
  assign all_map_done = &map_done;
  assign lane_start   = (state_r == T_MAP) && all_map_done;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (accept) state_nxt = T_MAP;
      T_MAP:   if (all_map_done) state_nxt = T_RUN;
      T_RUN:   if (load) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  etfl_map #(.DIM(IMG_HEIGHT)) u_map_row (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .pos    (POS_W'(in_row)),
    .origin (y_origin_r),
    .coord  (ci),
    .done   (map_done[LANE_COUNT])
  );

  for (genvar j = 0; j < LANE_COUNT; j++) begin : g_lane
    etfl_map #(.DIM(IMG_WIDTH)) u_map_col (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (accept),
      .pos    (POS_W'(in_column_base) + POS_W'(j)),
      .origin (x_origin_r),
      .coord  (cr[j]),
      .done   (map_done[j])
    );

    etfl_lane #(.MAX_ITER(MAX_ITER)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start),
      .take  (load),
      .cr    (cr[j]),
      .ci    (ci),
      .limit (limit_r),
      .res   (lane_res[j])
    );
  end

  etfl_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_res  (lane_res),
    .out_stall (out_stall),
    .load      (load),
    .out_valid (out_valid),
    .color     (m_color),
    .escaped   (m_esc)
  );

  assign out_color_lane0   = m_color[0];
  assign out_color_lane1   = m_color[1];
  assign out_color_lane2   = m_color[2];
  assign out_color_lane3   = m_color[3];
  assign out_escaped_lane0 = m_esc[0];
  assign out_escaped_lane1 = m_esc[1];
  assign out_escaped_lane2 = m_esc[2];
  assign out_escaped_lane3 = m_esc[3];

`ifndef NO_ASSERTIONS
  a_load_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (state_r == T_RUN))
    else $error("lane results merged outside the run phase");

  a_maps_together: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == T_MAP) && (|map_done)) |-> all_map_done)
    else $error("coordinate mappers finished at different cycles");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("merged request not presented");

  a_black_lane0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_escaped_lane0) |-> (out_color_lane0 == '0))
    else $error("lane 0 not escaped but color nonzero");
`endif

endmodule
